@@ sv/point_plane_query_unit_defines.svh @@
// Assertion macros for the point plane query unit.
`ifndef POINT_PLANE_QUERY_UNIT_DEFINES_SVH
`define POINT_PLANE_QUERY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PPQ_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("point_plane_query_unit: assertion failed");
`define PPQ_ASSERT_IMPLY(name, ante, cons) `PPQ_ASSERT(name, (ante) |-> (cons))
`else
`define PPQ_ASSERT(name, prop)
`define PPQ_ASSERT_IMPLY(name, ante, cons)
`endif

`endif

@@ sv/ppq_pkg.sv @@
`timescale 1ns / 1ps

package ppq_pkg;

    localparam int LANES          = 3;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_NORMAL_X     = 2'd0;
    localparam cfg_index_t REG_NORMAL_Y     = 2'd1;
    localparam cfg_index_t REG_NORMAL_Z     = 2'd2;
    localparam cfg_index_t REG_PLANE_OFFSET = 2'd3;

    typedef logic [1:0] side_t;

    localparam side_t SIDE_ON  = 2'd0;
    localparam side_t SIDE_POS = 2'd1;
    localparam side_t SIDE_NEG = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [LANES-1:0] neg;
    } div_ctl_t;

endpackage

@@ sv/ppq_div_step.sv @@
`timescale 1ns / 1ps

module ppq_div_step
    import ppq_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16,
    parameter int SHIFT      = 0
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  div_ctl_t                                ctl_in,
    input  logic [2*COORD_BITS-1:0]                 nn,
    input  logic [LANES-1:0][COORD_BITS + ((2*COORD_BITS > COORD_BITS+FRAC_BITS) ?
                  2*COORD_BITS : COORD_BITS+FRAC_BITS) + 2 - 1:0] rem_in,
    input  logic [LANES-1:0][COORD_BITS+1:0]        quo_in,
    input  logic [7*COORD_BITS-1:0]                 aux_in,
    output div_ctl_t                                ctl_out,
    output logic [LANES-1:0][COORD_BITS + ((2*COORD_BITS > COORD_BITS+FRAC_BITS) ?
                  2*COORD_BITS : COORD_BITS+FRAC_BITS) + 2 - 1:0] rem_out,
    output logic [LANES-1:0][COORD_BITS+1:0]        quo_out,
    output logic [7*COORD_BITS-1:0]                 aux_out
);

    localparam int W  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int DW = ((2*W > W+F) ? 2*W : W+F) + 2;
    localparam int AW = W + DW;
    localparam int QW = W + 2;

    logic [AW-1:0] dvs;
    logic [AW:0]   diff [LANES];
    logic [LANES-1:0][AW-1:0] rem_next;
    logic [LANES-1:0][QW-1:0] quo_next;

    div_ctl_t                 ctl_reg;
    logic [LANES-1:0][AW-1:0] rem_reg;
    logic [LANES-1:0][QW-1:0] quo_reg;
    logic [7*W-1:0]           aux_reg;

    assign dvs = AW'(nn) << SHIFT;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            diff[i]     = {1'b0, rem_in[i]} - {1'b0, dvs};
            rem_next[i] = diff[i][AW] ? rem_in[i] : diff[i][AW-1:0];
            quo_next[i] = {quo_in[i][QW-2:0], ~diff[i][AW]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (load)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            aux_reg <= aux_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign aux_out = aux_reg;

endmodule

@@ sv/point_plane_query_unit.sv @@
// Throughput: one word per cycle unless m_tready stalls the output; the depth comes
// from the closest-point divider, which resolves one quotient bit per pipeline stage
// on all three axes at once.
// Stalls collapse bubbles stage by stage, so input is taken while a result waits if some stage is empty.
// Reset clears the plane registers to zero and empties every pipeline stage.
`timescale 1ns / 1ps
`include "point_plane_query_unit_defines.svh"

module point_plane_query_unit
    import ppq_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // point_x, point_y, point_z
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]         s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // signed_distance, side, on_plane, reflected_x, reflected_y, reflected_z,
    // closest_x, closest_y, closest_z
    output logic [((7*COORD_BITS+3+7)/8)*8-1:0]       m_tdata,
    // zero_normal
    output logic [0:0]                                m_tuser,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  cfg_index_t                                cfg_index,
    input  logic [COORD_BITS-1:0]                     cfg_data
);

    localparam int W      = COORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int M_BITS = ((7*W+3+7)/8)*8;
    localparam int DW     = ((2*W > W+F) ? 2*W : W+F) + 2;
    localparam int PPW    = 2*W + 1;
    localparam int MW     = W + DW;
    localparam int AW     = MW;
    localparam int NW     = 2*W;
    localparam int QW     = W + 2;
    localparam int TWA    = W + 2*F;
    localparam int TWB    = MW + 1;
    localparam int SW     = ((TWA > TWB) ? TWA : TWB) + 1;
    localparam int NST    = 5 + QW + 1;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] sat_coord(input logic signed [SW-1:0] x);
        logic [SW-W:0] hi;
        hi = x[SW-1:W-1];
        if ((hi == '0) || (hi == '1))
        begin
            return x[W-1:0];
        end
        else if (x[SW-1])
        begin
            return MINV;
        end
        else
        begin
            return MAXV;
        end
    endfunction

    // Plane registers
    logic signed [W-1:0] nrm_reg [LANES];
    logic signed [W-1:0] offset_reg;
    logic                zero_nrm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                nrm_reg[i] <= '0;
            end
            offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NORMAL_X:     nrm_reg[0] <= cfg_data;
                REG_NORMAL_Y:     nrm_reg[1] <= cfg_data;
                REG_NORMAL_Z:     nrm_reg[2] <= cfg_data;
                REG_PLANE_OFFSET: offset_reg <= cfg_data;
                default:          offset_reg <= offset_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign zero_nrm  = (nrm_reg[0] == '0) && (nrm_reg[1] == '0) && (nrm_reg[2] == '0);

    // The normal must only change while the pipeline is empty (the block does not enforce this); n.n follows it freely.
    logic signed [2*W-1:0] sq_reg [LANES];
    logic [NW-1:0]         nn_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            sq_reg[i] <= nrm_reg[i] * nrm_reg[i];
        end
        nn_reg <= $unsigned(sq_reg[0]) + $unsigned(sq_reg[1]) + $unsigned(sq_reg[2]);
    end

    // Stall chain
    logic [NST:0]   en;
    logic [NST-1:0] stg_v;
    logic [4:0]     pipe_v_reg;
    logic           out_v_reg;

    assign en[NST] = m_tready;

    genvar gk;
    generate
        for (gk = 0; gk < NST; gk++)
        begin : g_en
            assign en[gk] = !stg_v[gk] || en[gk+1];
        end
    endgenerate

    assign s_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                pipe_v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < 5; k++)
            begin
                if (en[k])
                begin
                    pipe_v_reg[k] <= pipe_v_reg[k-1];
                end
            end
        end
    end

    // Stage 1: n_i * p_i
    logic signed [W-1:0]   pt_in [LANES];
    logic signed [2*W-1:0] prod1_reg [LANES];
    logic signed [W-1:0]   p1_reg [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            pt_in[i] = s_tdata[i*W +: W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                prod1_reg[i] <= nrm_reg[i] * pt_in[i];
                p1_reg[i]    <= pt_in[i];
            end
        end
    end

    // Stage 2: full-width distance n.p - c
    logic signed [DW-1:0] c_shift;
    logic signed [DW-1:0] df2_reg;
    logic signed [W-1:0]  p2_reg [LANES];

    assign c_shift = DW'(offset_reg) <<< F;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            df2_reg <= DW'(prod1_reg[0]) + DW'(prod1_reg[1]) + DW'(prod1_reg[2]) - c_shift;
            for (int i = 0; i < LANES; i++)
            begin
                p2_reg[i] <= p1_reg[i];
            end
        end
    end

    // Stage 3: partial products of n_i * distance, one W-bit slice each
    logic signed [3*W-1:0] df_ext;
    logic signed [PPW-1:0] pp_next [LANES][3];
    logic signed [PPW-1:0] pp3_reg [LANES][3];
    logic [W-1:0]          dist3_reg;
    logic signed [W-1:0]   p3_reg [LANES];

    always_comb
    begin
        df_ext = (3*W)'(df2_reg);
        for (int i = 0; i < LANES; i++)
        begin
            pp_next[i][0] = nrm_reg[i] * $signed({1'b0, df_ext[0 +: W]});
            pp_next[i][1] = nrm_reg[i] * $signed({1'b0, df_ext[W +: W]});
            pp_next[i][2] = nrm_reg[i] * $signed(df_ext[2*W +: W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pp3_reg[i][j] <= pp_next[i][j];
                end
                p3_reg[i] <= p2_reg[i];
            end
            dist3_reg <= sat_coord(SW'(df2_reg) >>> F);
        end
    end

    // Stage 4: n_i * distance
    logic signed [MW-1:0] m4_reg [LANES];
    logic [W-1:0]         dist4_reg;
    logic signed [W-1:0]  p4_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                m4_reg[i] <= MW'(pp3_reg[i][0]) + (MW'(pp3_reg[i][1]) <<< W)
                           + (MW'(pp3_reg[i][2]) <<< (2*W));
                p4_reg[i] <= p3_reg[i];
            end
            dist4_reg <= dist3_reg;
        end
    end

    // Stage 5: reflection, and the magnitude and sign of the closest-point numerator
    logic signed [SW-1:0] refl_t [LANES];
    logic [AW-1:0]        abs5_reg [LANES];
    logic [LANES-1:0]     neg5_reg;
    logic [7*W-1:0]       aux5_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            refl_t[i] = (SW'(p4_reg[i]) <<< (2*F)) - (SW'(m4_reg[i]) <<< 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                abs5_reg[i]               <= m4_reg[i][MW-1] ? AW'(-m4_reg[i]) : AW'(m4_reg[i]);
                neg5_reg[i]               <= !m4_reg[i][MW-1] && (m4_reg[i] != '0);
                aux5_reg[i*W +: W]        <= p4_reg[i];
                aux5_reg[(3+i)*W +: W]    <= sat_coord(refl_t[i] >>> (2*F));
            end
            aux5_reg[6*W +: W] <= dist4_reg;
        end
    end

    // Division stages: the first one yields the overflow bit, the rest the quotient.
    div_ctl_t                 ctl_bus [QW+1];
    logic [LANES-1:0][AW-1:0] rem_bus [QW+1];
    logic [LANES-1:0][QW-1:0] quo_bus [QW+1];
    logic [7*W-1:0]           aux_bus [QW+1];

    always_comb
    begin
        ctl_bus[0].valid = pipe_v_reg[4];
        ctl_bus[0].neg   = neg5_reg;
        for (int i = 0; i < LANES; i++)
        begin
            rem_bus[0][i] = abs5_reg[i];
        end
        quo_bus[0] = '0;
        aux_bus[0] = aux5_reg;
    end

    genvar gj;
    generate
        for (gj = 0; gj < QW; gj++)
        begin : g_div
            ppq_div_step #(
                .COORD_BITS (W),
                .FRAC_BITS  (F),
                .SHIFT      (QW-1-gj)
            ) u_step (
                .clk     (clk),
                .rst_n   (rst_n),
                .load    (en[5+gj]),
                .ctl_in  (ctl_bus[gj]),
                .nn      (nn_reg),
                .rem_in  (rem_bus[gj]),
                .quo_in  (quo_bus[gj]),
                .aux_in  (aux_bus[gj]),
                .ctl_out (ctl_bus[gj+1]),
                .rem_out (rem_bus[gj+1]),
                .quo_out (quo_bus[gj+1]),
                .aux_out (aux_bus[gj+1])
            );
        end
    endgenerate

    always_comb
    begin
        stg_v[4:0] = pipe_v_reg;
        for (int j = 0; j < QW; j++)
        begin
            stg_v[5+j] = ctl_bus[j+1].valid;
        end
        stg_v[NST-1] = out_v_reg;
    end

    // Output stage: signed floor quotient, add to the point, saturate; a zero normal passes the point through.
    logic [W-1:0]         fin_p    [LANES];
    logic signed [SW-1:0] q_mag    [LANES];
    logic signed [SW-1:0] q_val    [LANES];
    logic signed [SW-1:0] cl_sum   [LANES];
    logic [W-1:0]         cl_next  [LANES];
    logic [LANES-1:0]     rem_nz;
    logic [W-1:0]         fin_dist;
    side_t                side_next;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            fin_p[i]  = aux_bus[QW][i*W +: W];
            rem_nz[i] = |rem_bus[QW][i];
            q_mag[i]  = SW'($signed({1'b0, quo_bus[QW][i][W:0]}));
            q_val[i]  = ctl_bus[QW].neg[i]
                      ? (-q_mag[i] - SW'($signed({1'b0, rem_nz[i]}))) : q_mag[i];
            cl_sum[i] = SW'($signed(fin_p[i])) + q_val[i];
            if (zero_nrm)
            begin
                cl_next[i] = fin_p[i];
            end
            else if (quo_bus[QW][i][W+1])
            begin
                cl_next[i] = ctl_bus[QW].neg[i] ? MINV : MAXV;
            end
            else
            begin
                cl_next[i] = sat_coord(cl_sum[i]);
            end
        end
        fin_dist = aux_bus[QW][6*W +: W];
        if (fin_dist == '0)
        begin
            side_next = SIDE_ON;
        end
        else if (fin_dist[W-1])
        begin
            side_next = SIDE_NEG;
        end
        else
        begin
            side_next = SIDE_POS;
        end
    end

    logic [W-1:0] dist_o_reg;
    side_t        side_o_reg;
    logic         onp_o_reg;
    logic [W-1:0] refl_o_reg [LANES];
    logic [W-1:0] cl_o_reg   [LANES];
    logic         zero_o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en[NST-1])
        begin
            out_v_reg <= ctl_bus[QW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NST-1])
        begin
            dist_o_reg <= fin_dist;
            side_o_reg <= side_next;
            onp_o_reg  <= (fin_dist == '0);
            zero_o_reg <= zero_nrm;
            for (int i = 0; i < LANES; i++)
            begin
                refl_o_reg[i] <= aux_bus[QW][(3+i)*W +: W];
                cl_o_reg[i]   <= cl_next[i];
            end
        end
    end

    assign m_tvalid   = out_v_reg;
    assign m_tuser[0] = zero_o_reg;
    assign m_tdata    = M_BITS'({cl_o_reg[2], cl_o_reg[1], cl_o_reg[0],
                                 refl_o_reg[2], refl_o_reg[1], refl_o_reg[0],
                                 onp_o_reg, side_o_reg, dist_o_reg});

    `PPQ_ASSERT_IMPLY(a_empty_output_opens_input, !m_tvalid, s_tready)
    `PPQ_ASSERT_IMPLY(a_sink_ready_opens_input, m_tready, s_tready)
    `PPQ_ASSERT_IMPLY(a_on_plane_matches, m_tvalid && onp_o_reg,
                      (side_o_reg == SIDE_ON) && (dist_o_reg == '0))
    `PPQ_ASSERT_IMPLY(a_off_plane_has_side, m_tvalid && !onp_o_reg,
                      (side_o_reg == SIDE_POS) || (side_o_reg == SIDE_NEG))

endmodule
